// ===== src/lba_pkg.sv =====
`default_nettype none

package lba_pkg;

  // Store geometry.
  localparam int NUM_BLOCKS = 256;
  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = BLK_W + 1;
  localparam int NXT_W      = CNT_W;
  localparam int ID_W       = 16;

  // Link value that closes a chain.
  localparam logic [NXT_W-1:0] END_MARK = NXT_W'(NUM_BLOCKS);

  // Stream word widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // Request kinds carried on in_tuser.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOID    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_ALINK,
    S_RSCAN,
    S_WREAD,
    S_WSTEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             action;
    logic [CNT_W-1:0] block_count;
    logic [ID_W-1:0]  file_id;
    logic [BLK_W-1:0] start_block;
  } request_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] first_block;
    logic [ID_W-1:0]  assigned_id;
    logic [CNT_W-1:0] free_blocks;
  } result_t;

  // Port bundle for the link table.
  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic [NXT_W-1:0] wdata;
    logic [BLK_W-1:0] raddr;
  } nxt_port_t;

  // Port bundle for the owner table.
  typedef struct packed {
    logic             we;
    logic [BLK_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic [BLK_W-1:0] raddr;
  } own_port_t;

endpackage

`default_nettype wire

// ===== src/lba_ram.sv =====
`default_nettype none

module lba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/lba_ctrl.sv =====
`default_nettype none

module lba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire lba_pkg::request_t  req,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output lba_pkg::result_t        res,
  output lba_pkg::nxt_port_t      nxt_port,
  input  wire logic [lba_pkg::NXT_W-1:0] nxt_rdata,
  output lba_pkg::own_port_t      own_port,
  input  wire logic [lba_pkg::ID_W-1:0]  own_rdata
);

  import lba_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] addr_r;
  logic             pend_vld_r;
  logic [BLK_W-1:0] pend_addr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] taken_r;
  logic [CNT_W-1:0] freed_r;
  logic [BLK_W-1:0] prev_r;
  logic [BLK_W-1:0] first_r;
  logic [BLK_W-1:0] blk_r;
  logic [BLK_W-1:0] steps_r;
  logic [ID_W-1:0]  id_r;
  logic [ID_W-1:0]  next_id_r;
  logic [CNT_W-1:0] free_cnt_r;
  result_t          res_r;

  logic             take;
  logic             hit;
  logic             scan_end;
  logic [CNT_W-1:0] taken_inc;
  logic             walk_stop;

  // Scan and walk decisions on the data returned by the tables.
  assign take      = pend_vld_r && (own_rdata == '0);
  assign hit       = pend_vld_r && (own_rdata == id_r);
  assign scan_end  = addr_r[BLK_W] && !pend_vld_r;
  assign taken_inc = taken_r + CNT_W'(1);
  assign walk_stop = (nxt_rdata == '0) || nxt_rdata[BLK_W] ||
                     (steps_r == BLK_W'(NUM_BLOCKS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (addr_r == CNT_W'(NUM_BLOCKS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req.action == ACT_FREE) begin
            state_nxt = (req.file_id == '0) ? S_DONE : S_RSCAN;
          end else if ((req.block_count == '0) || (req.block_count > free_cnt_r)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        if ((take && (taken_inc == count_r)) || scan_end) state_nxt = S_ALINK;
      end
      S_ALINK: state_nxt = S_DONE;
      S_RSCAN: begin
        if (scan_end) state_nxt = (freed_r == '0) ? S_DONE : S_WREAD;
      end
      S_WREAD: state_nxt = S_WSTEP;
      S_WSTEP: state_nxt = walk_stop ? S_DONE : S_WREAD;
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshakes and table ports.
  always_comb begin
    req_ready = (state_r == S_IDLE);
    res_valid = (state_r == S_DONE);
    res       = res_r;

    own_port.raddr = addr_r[BLK_W-1:0];
    own_port.we    = 1'b0;
    own_port.waddr = pend_addr_r;
    own_port.wdata = '0;

    nxt_port.raddr = blk_r;
    nxt_port.we    = 1'b0;
    nxt_port.waddr = blk_r;
    nxt_port.wdata = '0;

    unique case (state_r)
      S_CLEAR: begin
        own_port.we    = 1'b1;
        own_port.waddr = addr_r[BLK_W-1:0];
        nxt_port.we    = 1'b1;
        nxt_port.waddr = addr_r[BLK_W-1:0];
      end
      S_ASCAN: begin
        own_port.we    = take;
        own_port.wdata = id_r;
        // Link the previous block of the chain to this one.
        nxt_port.we    = take && (taken_r != '0);
        nxt_port.waddr = prev_r;
        nxt_port.wdata = {1'b0, pend_addr_r};
      end
      S_ALINK: begin
        nxt_port.we    = 1'b1;
        nxt_port.waddr = prev_r;
        nxt_port.wdata = END_MARK;
      end
      S_RSCAN: begin
        own_port.we = hit;
      end
      S_WSTEP: begin
        nxt_port.we = 1'b1;
      end
      S_IDLE, S_WREAD, S_DONE: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      addr_r     <= '0;
      pend_vld_r <= 1'b0;
      next_id_r  <= ID_W'(1);
      free_cnt_r <= CNT_W'(NUM_BLOCKS);
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_CLEAR: addr_r <= addr_r + CNT_W'(1);
        S_IDLE: begin
          addr_r     <= '0;
          pend_vld_r <= 1'b0;
        end
        S_ASCAN, S_RSCAN: begin
          if (!addr_r[BLK_W]) addr_r <= addr_r + CNT_W'(1);
          pend_vld_r <= !addr_r[BLK_W];
          if (state_r == S_RSCAN && scan_end) free_cnt_r <= free_cnt_r + freed_r;
        end
        S_ALINK: begin
          free_cnt_r <= free_cnt_r - count_r;
          next_id_r  <= (next_id_r == '1) ? ID_W'(1) : next_id_r + ID_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Request data, scan bookkeeping and the result.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        taken_r <= '0;
        freed_r <= '0;
        steps_r <= '0;
        count_r <= req.block_count;
        blk_r   <= req.start_block;
        id_r    <= (req.action == ACT_FREE) ? req.file_id : next_id_r;
        res_r.first_block <= '0;
        res_r.assigned_id <= '0;
        res_r.free_blocks <= free_cnt_r;
        if (req.action == ACT_FREE) begin
          res_r.status <= ST_NOID;
        end else if (req.block_count == '0) begin
          res_r.status <= ST_OK;
        end else begin
          res_r.status <= ST_NOSPACE;
        end
      end
      S_ASCAN: begin
        pend_addr_r <= addr_r[BLK_W-1:0];
        if (take) begin
          taken_r <= taken_inc;
          prev_r  <= pend_addr_r;
          if (taken_r == '0) first_r <= pend_addr_r;
        end
      end
      S_ALINK: begin
        res_r <= '{status: ST_OK, first_block: first_r, assigned_id: id_r,
                   free_blocks: free_cnt_r - count_r};
      end
      S_RSCAN: begin
        pend_addr_r <= addr_r[BLK_W-1:0];
        if (hit) freed_r <= freed_r + CNT_W'(1);
      end
      S_WSTEP: begin
        res_r <= '{status: ST_OK, first_block: '0, assigned_id: '0,
                   free_blocks: free_cnt_r};
        if (!walk_stop) begin
          blk_r   <= nxt_rdata[BLK_W-1:0];
          steps_r <= steps_r + BLK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/linked_block_allocator.sv =====
`default_nettype none

// Linked block allocator over a store of 256 blocks, chained like a file
// allocation table. An allocate word (in_tuser low) takes the lowest free
// blocks first-fit, links them in ascending order and tags them with a fresh
// owner id; a free word (in_tuser high) clears the link chain from its start
// block and releases every block owned by its id. Each request gives one
// result word. After reset both tables are cleared in a pass over every block
// before the first request is taken. The owner table is read one entry per
// cycle: an allocate scans it until enough free blocks are taken and then
// closes the chain with the end mark; a free sweeps the whole owner table and
// then walks the link chain, reading and clearing each link. A result waits
// in an output register while the next request is accepted.
module linked_block_allocator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // block_count [8:0], file_id [24:9], start_block [32:25], zero fill above
  input  wire logic [lba_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action [0]
  input  wire logic                               in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // first_block [7:0], assigned_id [23:8], free_blocks [32:24], zero fill above
  output logic [lba_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // status [1:0]
  output logic [1:0]                              out_tuser
);

  import lba_pkg::*;

  request_t   req;
  result_t    res;
  logic       res_valid;
  logic       res_ready;
  nxt_port_t  nxt_port;
  own_port_t  own_port;
  logic [NXT_W-1:0] nxt_rdata;
  logic [ID_W-1:0]  own_rdata;

  logic       out_vld_r;
  result_t    out_res_r;

  // Unpack the request word.
  assign req.action      = in_tuser;
  assign req.block_count = in_tdata[8:0];
  assign req.file_id     = in_tdata[24:9];
  assign req.start_block = in_tdata[32:25];

  lba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .nxt_port  (nxt_port),
    .nxt_rdata (nxt_rdata),
    .own_port  (own_port),
    .own_rdata (own_rdata)
  );

  // Link table: next block of each chain, or the end marker.
  lba_ram #(.WIDTH(NXT_W), .DEPTH(NUM_BLOCKS)) u_next_ram (
    .clk   (clk),
    .we    (nxt_port.we),
    .waddr (nxt_port.waddr),
    .wdata (nxt_port.wdata),
    .raddr (nxt_port.raddr),
    .rdata (nxt_rdata)
  );

  // Owner table: zero marks a free block.
  lba_ram #(.WIDTH(ID_W), .DEPTH(NUM_BLOCKS)) u_owner_ram (
    .clk   (clk),
    .we    (own_port.we),
    .waddr (own_port.waddr),
    .wdata (own_port.wdata),
    .raddr (own_port.raddr),
    .rdata (own_rdata)
  );

  // Output register; it frees up in the same cycle its word is taken.
  assign res_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {7'd0, out_res_r.free_blocks, out_res_r.assigned_id,
                       out_res_r.first_block};

  // A result never reports more free blocks than the store holds.
  a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_res_r.free_blocks <= CNT_W'(NUM_BLOCKS)))
    else $error("free block count beyond store size");

  // Failed requests carry no chain and no id.
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.status == ST_NOSPACE || out_res_r.status == ST_NOID))
    |-> (out_res_r.first_block == '0 && out_res_r.assigned_id == '0))
    else $error("failed request returned a chain");

  // Requests are only taken between the end of the clearing pass and a result.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !in_tready)
    else $error("request accepted while a result is pending in the controller");

endmodule

`default_nettype wire

// ===== tb/lba_checker.sv =====
`default_nettype none

// Watches both streams of the allocator, keeps its own copy of the link and
// owner tables, and checks every result word against the oldest prediction.
module lba_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  // block_count [8:0], file_id [24:9], start_block [32:25], zero fill above
  input  wire logic [lba_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action [0]
  input  wire logic                            in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // first_block [7:0], assigned_id [23:8], free_blocks [32:24], zero fill above
  input  wire logic [lba_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status [1:0]
  input  wire logic [1:0]                      out_tuser,
  output int                                   fail_count,
  output int                                   outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  import lba_pkg::*;

  // Shadow copy of the block store.
  logic [NXT_W-1:0] link_tab  [NUM_BLOCKS];
  logic [ID_W-1:0]  owner_tab [NUM_BLOCKS];
  logic [ID_W-1:0]  fresh_id;
  logic [CNT_W-1:0] blocks_left;

  result_t expected_q [$];
  result_t want;
  request_t req;
  int errs = 0;

  // Works out the result word of one request and updates the shadow store.
  task automatic predict_request(input request_t rq);
    result_t     res;
    int unsigned taken;
    int unsigned prev;
    int unsigned b;
    int unsigned nx;
    bit          found;
    res   = '{status: ST_OK, first_block: '0, assigned_id: '0, free_blocks: '0};
    taken = 0;
    prev  = 0;
    found = 1'b0;
    if (rq.action == ACT_ALLOC) begin
      if (rq.block_count > blocks_left) begin
        res.status = ST_NOSPACE;
      end else if (rq.block_count != '0) begin
        // First fit over the lowest free blocks, linked in ascending order.
        for (int i = 0; i < NUM_BLOCKS && taken < 32'(rq.block_count); i++) begin
          if (owner_tab[BLK_W'(i)] == '0) begin
            owner_tab[BLK_W'(i)] = fresh_id;
            link_tab[BLK_W'(i)]  = END_MARK;
            if (taken == 0) begin
              res.first_block = BLK_W'(i);
            end else begin
              link_tab[BLK_W'(prev)] = NXT_W'(i);
            end
            prev = 32'(i);
            taken++;
          end
        end
        blocks_left     = blocks_left - CNT_W'(taken);
        res.assigned_id = fresh_id;
        fresh_id        = fresh_id + ID_W'(1);
        if (fresh_id == '0) begin
          fresh_id = ID_W'(1);
        end
      end
    end else begin
      if (rq.file_id != '0) begin
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          if (owner_tab[BLK_W'(i)] == rq.file_id) begin
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        res.status = ST_NOID;
      end else begin
        // Clear links along the chain, whatever chain the start block is on.
        b = 32'(rq.start_block);
        for (int steps = 0; steps < NUM_BLOCKS && b < NUM_BLOCKS; steps++) begin
          nx = 32'(link_tab[BLK_W'(b)]);
          link_tab[BLK_W'(b)] = '0;
          if (nx == 0 || nx >= NUM_BLOCKS) begin
            break;
          end
          b = nx;
        end
        // Owners are released by id alone.
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          if (owner_tab[BLK_W'(i)] == rq.file_id) begin
            owner_tab[BLK_W'(i)] = '0;
            blocks_left = blocks_left + CNT_W'(1);
          end
        end
      end
    end
    res.free_blocks = blocks_left;
    expected_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        link_tab[BLK_W'(i)]  = '0;
        owner_tab[BLK_W'(i)] = '0;
      end
      fresh_id    = ID_W'(1);
      blocks_left = CNT_W'(NUM_BLOCKS);
      expected_q.delete();
    end else begin
      // Result word: compare with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no request waiting: status %0d", out_tuser);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (out_tuser != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            errs++;
          end
          if (out_tdata[7:0] != want.first_block) begin
            $error("first_block: expected %0d, got %0d", want.first_block, out_tdata[7:0]);
            errs++;
          end
          if (out_tdata[23:8] != want.assigned_id) begin
            $error("assigned_id: expected %0d, got %0d", want.assigned_id, out_tdata[23:8]);
            errs++;
          end
          if (out_tdata[32:24] != want.free_blocks) begin
            $error("free_blocks: expected %0d, got %0d", want.free_blocks, out_tdata[32:24]);
            errs++;
          end
        end
      end
      // Request word: predict its result.
      if (in_tvalid && in_tready) begin
        req.action      = in_tuser;
        req.block_count = in_tdata[8:0];
        req.file_id     = in_tdata[24:9];
        req.start_block = in_tdata[32:25];
        predict_request(req);
      end
    end
    fail_count  <= errs;
    outstanding <= expected_q.size();
  end

endmodule

`default_nettype wire

// ===== tb/linked_block_allocator_tb.sv =====
`default_nettype none

// Drives allocate and free requests into the allocator with random gaps and
// back pressure; the checker beside the block does the predicting.
module linked_block_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import lba_pkg::*;

  localparam int RANDOM_WORDS = 1380;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    logic [ID_W-1:0]  owner;
    logic [BLK_W-1:0] head;
  } chain_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   calm       = 1'b0;

  int fail_count;
  int outstanding;
  int stall_cycles = 0;
  int free_seen    = NUM_BLOCKS;

  // Chains whose allocation has come back and that are not yet freed.
  chain_t live_chains [$];

  linked_block_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  lba_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random back pressure, and a note of every chain handed out.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 38);
    if (rst_n && out_tvalid && out_tready) begin
      free_seen = int'(out_tdata[32:24]);
      if (out_tuser == ST_OK && out_tdata[23:8] != '0) begin
        live_chains.push_back('{owner: out_tdata[23:8], head: out_tdata[7:0]});
      end
    end
  end

  // Cycles since the last word moved on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Presents one request word and holds it until it is taken.
  task automatic send_word(input logic act, input logic [CNT_W-1:0] cnt,
                           input logic [ID_W-1:0] fid, input logic [BLK_W-1:0] sb);
    while (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'b0, sb, fid, cnt};
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly well-formed frees of live chains and small allocations, with some
  // wrong starts, unknown ids, empty counts and oversized counts mixed in.
  task automatic random_word();
    int     roll;
    int     pick;
    int     k;
    chain_t c;
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    if (live_chains.size() > 0 && (roll < 40 || (free_seen < 16 && roll < 80))) begin
      k = $urandom_range(live_chains.size() - 1);
      c = live_chains[k];
      live_chains.delete(k);
      send_word(ACT_FREE, CNT_W'($urandom), c.owner,
                (pick < 85) ? c.head : BLK_W'($urandom));
    end else if (roll < 52) begin
      send_word(ACT_FREE, CNT_W'($urandom), (pick < 20) ? '0 : ID_W'($urandom),
                BLK_W'($urandom));
    end else begin
      if (pick < 4) begin
        k = 0;
      end else if (pick < 9) begin
        k = $urandom_range(256, 511);
      end else if (pick < 13) begin
        k = free_seen + 1;
      end else if (pick < 17) begin
        k = free_seen;
      end else if (pick < 80) begin
        k = $urandom_range(1, 12);
      end else begin
        k = $urandom_range(13, 64);
      end
      send_word(ACT_ALLOC, CNT_W'(k), ID_W'($urandom), BLK_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty and oversized counts, unknown ids, a gap in the
    // free list, a full store, wrong start blocks and the last block.
    send_word(ACT_ALLOC, 9'd0,   16'd0,      8'd0);
    send_word(ACT_FREE,  9'd0,   16'd0,      8'd0);
    send_word(ACT_FREE,  9'd0,   16'd5,      8'd0);
    send_word(ACT_ALLOC, 9'd1,   16'd0,      8'd0);
    send_word(ACT_ALLOC, 9'd3,   16'd0,      8'd0);
    send_word(ACT_ALLOC, 9'd257, 16'd0,      8'd0);
    send_word(ACT_ALLOC, 9'd511, 16'hFFFF,   8'hFF);
    send_word(ACT_FREE,  9'd0,   16'd1,      8'd0);
    send_word(ACT_ALLOC, 9'd2,   16'd0,      8'd0);
    send_word(ACT_FREE,  9'd0,   16'd2,      8'd200);
    send_word(ACT_FREE,  9'd0,   16'd3,      8'd0);
    send_word(ACT_ALLOC, 9'd256, 16'd0,      8'd0);
    send_word(ACT_ALLOC, 9'd1,   16'd0,      8'd0);
    send_word(ACT_ALLOC, 9'd0,   16'd0,      8'd0);
    send_word(ACT_FREE,  9'd0,   16'd4,      8'd0);
    send_word(ACT_FREE,  9'd0,   16'd4,      8'd0);
    send_word(ACT_ALLOC, 9'd255, 16'd0,      8'd0);
    send_word(ACT_ALLOC, 9'd1,   16'd0,      8'd0);
    send_word(ACT_FREE,  9'h1FF, 16'hFFFF,   8'hFF);
    send_word(ACT_FREE,  9'd0,   16'd5,      8'd128);
    send_word(ACT_FREE,  9'd0,   16'd6,      8'd255);

    // Random part, with a stretch of steady flow on both sides.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm <= (n >= 500 && n < 700);
      random_word();
    end
    in_tvalid <= 1'b0;
    calm      <= 1'b0;

    // Let the checker see the last request, then drain.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
